// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkv_table and lru_key_value_cache.
package lkv_pkg;

   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;
   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] value;
   } lookup_type;

endpackage

// ===== design/lkv_table.sv =====
// Entry store, parallel key match and recency bookkeeping of the LRU cache.
// Depends on lkv_pkg.
module lkv_table #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  lkv_pkg::req_type          req,
   input  logic [lkv_pkg::CAP_W-1:0] capacity,
   output lkv_pkg::lookup_type       lookup
);
   import lkv_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   logic [DATA_W-1:0] key_ff   [ENTRIES];
   logic [DATA_W-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0] rank_ff  [ENTRIES];
   logic [RANK_W-1:0] rank_in  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   logic [ENTRIES-1:0] hit, victim, valid_after, free_slots, slot;
   logic [ENTRIES-1:0] key_we, value_we;
   logic               hit_any, evict, is_put;
   logic [RANK_W-1:0]  hit_rank, last_rank;
   logic [DATA_W-1:0]  hit_value;
   logic [OCC_W-1:0]   occ_less;
   logic [CMP_W-1:0]   cap_ext, eff_cap, occ_ext;

   assign is_put = (req.op == OP_PUT);

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (hit[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      hit_any = |hit;
   end

   // Clamp the capacity into 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity);
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end
   end

   assign occ_ext   = CMP_W'(occ_ff);
   assign evict     = (occ_ext >= eff_cap) || (occ_ext >= CMP_W'(ENTRIES));
   assign occ_less  = occ_ff - OCC_W'(1);
   assign last_rank = occ_less[RANK_W-1:0];

   // Ranks of valid entries form 0..occupancy-1, so the oldest holds occupancy-1
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = evict && valid_ff[i] && (rank_ff[i] == last_rank);
      end
   end

   assign valid_after = valid_ff & ~victim;
   assign free_slots  = ~valid_after;
   assign slot        = free_slots & (~free_slots + ENTRIES'(1));

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      key_we   = '0;
      value_we = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (fire && hit_any) begin
         // touch: entries more recent than the hit age by one
         for (int i = 0; i < ENTRIES; i++) begin
            if (hit[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         if (is_put) begin
            value_we = hit;
         end
      end else if (fire && is_put) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot[i] || victim[i]) begin
               rank_in[i] = '0;
            end else if (valid_after[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         valid_in = valid_after | slot;
         occ_in   = evict ? occ_ff : occ_ff + OCC_W'(1);
         key_we   = slot;
         value_we = slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= req.key;
         end
         if (value_we[i]) begin
            value_ff[i] <= req.value;
         end
      end
   end

   assign lookup.found = hit_any;
   assign lookup.value = hit_any ? hit_value : {DATA_W{1'b1}};

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: request register, response register, capacity.
// Depends on lkv_pkg and lkv_table.
//
// Fully associative key-value cache with least-recently-used replacement over ENTRIES
// slots. A get (op 0) returns found and the stored value, or found 0 with value -1 on a
// miss; a put (op 1) updates or inserts and returns nothing. Sustained rate is one
// transaction per cycle unless a stalled response holds a get: the request register
// feeds a parallel key compare and recency update across all entries, and gets answer
// through an output register. A stalled response holds back only a get and all behind
// it; a put advances. csr_write_data sets how many entries are held before eviction
// (0 acts as 1, values above ENTRIES act as ENTRIES) and must be written while idle.
module lru_key_value_cache #(
   parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic signed [lkv_pkg::DATA_W-1:0] req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic signed [lkv_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                              csr_write_enable,
   input  logic [lkv_pkg::CAP_W-1:0]         csr_write_data
);
   import lkv_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_req_ff, s1_req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lookup_type         rsp_ff, rsp_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   lookup_type         lookup;
   logic               accept, advance, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && ((s1_req_ff.op == OP_PUT) || out_free);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   lkv_table #(.ENTRIES(ENTRIES)) u_table (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .req      (s1_req_ff),
      .capacity (cap_ff),
      .lookup   (lookup)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_req_in   = '{op: req_op, key: req_key, value: req_value};
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && (s1_req_ff.op == OP_GET)) begin
         rsp_valid_in = 1'b1;
         rsp_in       = lookup;
      end else if (!rsp_stall) begin
         // drop the response once taken
         rsp_valid_in = 1'b0;
      end

      cap_in = csr_write_enable ? csr_write_data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_ff.found;
   assign rsp_read_value = rsp_ff.value;

endmodule
